>>> rtl/file_offset_to_sector_map_defines.svh
// Assertion macros used by the back part of the file offset to sector map RTL.
`ifndef FILE_OFFSET_TO_SECTOR_MAP_DEFINES_SVH
`define FILE_OFFSET_TO_SECTOR_MAP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define FOM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define FOM_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FOM_ASSERT(label, prop, msg)
`define FOM_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> rtl/fom_pkg.sv
// Types and constants shared by the file offset to sector map modules.
package fom_pkg;

	localparam int OFF_W     = 21;
	localparam int SEC_W     = 16;
	localparam int IDX_W     = 12;
	localparam int TYPE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 21;

	// Request type codes.
	localparam logic [TYPE_W-1:0] REQ_LOOKUP    = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_WR_DIRECT = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_WR_SINGLE = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_WR_SECOND = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_BYTES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INDIRECT_LIMIT = 2'd2;

	localparam logic [CFG_W-1:0] RST_FILE_BYTES     = 21'd0;
	localparam logic [CFG_W-1:0] RST_DIRECT_LIMIT   = 21'd15872;
	localparam logic [CFG_W-1:0] RST_INDIRECT_LIMIT = 21'd32000;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef enum logic [2:0] {
		OP_WR_DIR,
		OP_WR_SGL,
		OP_WR_SEC,
		OP_RD_DIR,
		OP_RD_SGL,
		OP_RD_SEC,
		OP_OOR
	} op_kind_t;

	// Classified operation handed from the front to the back part. The address
	// is OFF_W bits wide, enough for any table entry at the default parameters.
	typedef struct packed {
		op_kind_t           kind;
		logic [OFF_W-1:0]   addr;
		logic [SEC_W-1:0]   data;
	} op_t;

endpackage

>>> rtl/fom_front.sv
// Front part: configuration registers and classification of each request.
module fom_front #(
	parameter int SECTOR_BYTES        = 256,
	parameter int POINTERS_PER_SECTOR = 64,
	parameter int DIRECT_SLOTS        = 62
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fom_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fom_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [fom_pkg::TYPE_W-1:0]      req_type,
	input  logic [fom_pkg::IDX_W-1:0]       entry_index,
	input  logic [fom_pkg::SEC_W-1:0]       sector_value,
	input  logic [fom_pkg::OFF_W-1:0]       byte_offset,
	output logic                            op_valid,
	input  logic                            op_ready,
	output fom_pkg::op_t                    op
);
	import fom_pkg::*;

	localparam int SB_SHIFT  = $clog2(SECTOR_BYTES);
	localparam int SEC_DEPTH = POINTERS_PER_SECTOR * POINTERS_PER_SECTOR;

	localparam logic [OFF_W-1:0] DIR_END   = OFF_W'(DIRECT_SLOTS);
	localparam logic [OFF_W-1:0] SGL_DEPTH = OFF_W'(POINTERS_PER_SECTOR);
	localparam logic [OFF_W-1:0] SEC_END   = OFF_W'(SEC_DEPTH);
	localparam logic [OFF_W-1:0] S_DIR_END = OFF_W'(DIRECT_SLOTS - 1);
	localparam logic [OFF_W-1:0] S_SGL_END = OFF_W'(DIRECT_SLOTS - 1 + POINTERS_PER_SECTOR);
	localparam logic [OFF_W-1:0] D_DIR_END = OFF_W'(DIRECT_SLOTS - 2);
	localparam logic [OFF_W-1:0] D_SGL_END = OFF_W'(DIRECT_SLOTS - 2 + POINTERS_PER_SECTOR);
	localparam logic [OFF_W-1:0] D_SEC_END =
		OFF_W'(DIRECT_SLOTS - 2 + POINTERS_PER_SECTOR + SEC_DEPTH);

	logic [CFG_W-1:0] file_bytes_q;
	logic [CFG_W-1:0] direct_limit_q;
	logic [CFG_W-1:0] indirect_limit_q;

	logic [OFF_W-1:0] idx;
	logic [OFF_W-1:0] ix_ext;
	logic             past_end;
	logic             lay_direct;
	logic             lay_single;
	logic             keep;
	op_t              op_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_bytes_q     <= RST_FILE_BYTES;
			direct_limit_q   <= RST_DIRECT_LIMIT;
			indirect_limit_q <= RST_INDIRECT_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FILE_BYTES:     file_bytes_q     <= cfg_data;
				CFG_DIRECT_LIMIT:   direct_limit_q   <= cfg_data;
				CFG_INDIRECT_LIMIT: indirect_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign idx        = byte_offset >> SB_SHIFT;
	assign ix_ext     = OFF_W'(entry_index);
	assign past_end   = byte_offset >= file_bytes_q;
	assign lay_direct = file_bytes_q <= direct_limit_q;
	assign lay_single = file_bytes_q <= indirect_limit_q;

	always_comb begin
		op_d.kind = OP_OOR;
		op_d.addr = '0;
		op_d.data = sector_value;
		keep      = 1'b1;
		case (req_type)
			REQ_WR_DIRECT: begin
				op_d.kind = OP_WR_DIR;
				op_d.addr = ix_ext;
				keep      = ix_ext < DIR_END;
			end
			REQ_WR_SINGLE: begin
				op_d.kind = OP_WR_SGL;
				op_d.addr = ix_ext;
				keep      = ix_ext < SGL_DEPTH;
			end
			REQ_WR_SECOND: begin
				op_d.kind = OP_WR_SEC;
				op_d.addr = ix_ext;
				keep      = ix_ext < SEC_END;
			end
			REQ_LOOKUP: begin
				if (past_end) begin
					op_d.kind = OP_OOR;
				end else if (lay_direct) begin
					if (idx < DIR_END) begin
						op_d.kind = OP_RD_DIR;
						op_d.addr = idx;
					end
				end else if (lay_single) begin
					if (idx < S_DIR_END) begin
						op_d.kind = OP_RD_DIR;
						op_d.addr = idx;
					end else if (idx < S_SGL_END) begin
						op_d.kind = OP_RD_SGL;
						op_d.addr = idx - S_DIR_END;
					end
				end else begin
					if (idx < D_DIR_END) begin
						op_d.kind = OP_RD_DIR;
						op_d.addr = idx;
					end else if (idx < D_SGL_END) begin
						op_d.kind = OP_RD_SGL;
						op_d.addr = idx - D_DIR_END;
					end else if (idx < D_SEC_END) begin
						op_d.kind = OP_RD_SEC;
						op_d.addr = idx - D_SGL_END;
					end
				end
			end
			default: keep = 1'b0;
		endcase
	end

	// A write beyond its table is taken and dropped without reaching the queue.
	assign req_ready = op_ready;
	assign op_valid  = req_valid && keep;
	assign op        = op_d;

endmodule

>>> rtl/fom_fifo.sv
// Short queue of classified operations between the front and back parts.
module fom_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fom_pkg::op_t  in_op,
	output logic          out_valid,
	input  logic          out_ready,
	output fom_pkg::op_t  out_op
);
	import fom_pkg::*;

	op_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_op    = slots_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/fom_back.sv
// Back part: the three sector tables, the read stage and the result register.
`include "file_offset_to_sector_map_defines.svh"

module fom_back #(
	parameter int POINTERS_PER_SECTOR = 64,
	parameter int DIRECT_SLOTS        = 62
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       op_valid,
	output logic                       op_ready,
	input  fom_pkg::op_t               op,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [fom_pkg::SEC_W-1:0]  sector,
	output logic                       out_of_range
);
	import fom_pkg::*;

	localparam int SEC_DEPTH = POINTERS_PER_SECTOR * POINTERS_PER_SECTOR;
	localparam int DIR_AW    = $clog2(DIRECT_SLOTS);
	localparam int SGL_AW    = $clog2(POINTERS_PER_SECTOR);
	localparam int SEC_AW    = $clog2(SEC_DEPTH);

	logic [SEC_W-1:0] dir_mem [DIRECT_SLOTS];
	logic [SEC_W-1:0] sgl_mem [POINTERS_PER_SECTOR];
	logic [SEC_W-1:0] sec_mem [SEC_DEPTH];

	logic [SEC_W-1:0] dir_rd_q;
	logic [SEC_W-1:0] sgl_rd_q;
	logic [SEC_W-1:0] sec_rd_q;

	logic             s1_v_q;
	op_kind_t         kind_s1;
	logic             out_v_q;
	logic [SEC_W-1:0] sector_q;
	logic             oor_q;

	logic             is_rd;
	logic             s1_adv;
	logic             pop;
	logic [SEC_W-1:0] sector_d;
	logic             oor_d;

	// Lookups and range misses occupy the read stage; writes finish at the pop.
	assign is_rd    = (op.kind == OP_RD_DIR) || (op.kind == OP_RD_SGL) ||
	                  (op.kind == OP_RD_SEC) || (op.kind == OP_OOR);
	assign s1_adv   = s1_v_q && (!out_v_q || res_ready);
	assign op_ready = !is_rd || !s1_v_q || s1_adv;
	assign pop      = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (pop && op.kind == OP_WR_DIR) begin
			dir_mem[op.addr[DIR_AW-1:0]] <= op.data;
		end
		if (pop && op.kind == OP_RD_DIR) begin
			dir_rd_q <= dir_mem[op.addr[DIR_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.kind == OP_WR_SGL) begin
			sgl_mem[op.addr[SGL_AW-1:0]] <= op.data;
		end
		if (pop && op.kind == OP_RD_SGL) begin
			sgl_rd_q <= sgl_mem[op.addr[SGL_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.kind == OP_WR_SEC) begin
			sec_mem[op.addr[SEC_AW-1:0]] <= op.data;
		end
		if (pop && op.kind == OP_RD_SEC) begin
			sec_rd_q <= sec_mem[op.addr[SEC_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (!s1_v_q || s1_adv) begin
			s1_v_q <= pop && is_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_rd) begin
			kind_s1 <= op.kind;
		end
	end

	always_comb begin
		sector_d = '0;
		oor_d    = 1'b0;
		case (kind_s1)
			OP_RD_DIR: sector_d = dir_rd_q;
			OP_RD_SGL: sector_d = sgl_rd_q;
			OP_RD_SEC: sector_d = sec_rd_q;
			default:   oor_d    = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (res_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sector_q <= sector_d;
			oor_q    <= oor_d;
		end
	end

	assign res_valid    = out_v_q;
	assign sector       = sector_q;
	assign out_of_range = oor_q;

	`FOM_ASSERT(a_oor_zero_sector, (out_v_q && oor_q) |-> (sector_q == '0), "miss with sector")
	`FOM_ASSERT(a_adv_fills_out, s1_adv |=> out_v_q, "read stage moved but no result")
	`FOM_ASSERT(a_stall_holds_kind, (s1_v_q && !s1_adv) |=> (s1_v_q && $stable(kind_s1)), "stage lost")
	`FOM_ASSERT_NEVER(a_no_issue_on_stall, pop && is_rd && s1_v_q && !s1_adv, "read over stall")

endmodule

>>> rtl/file_offset_to_sector_map.sv
// Top level of the file offset to sector map: front, queue and back parts.
//
//  Channel   Handshake              Payload
//  cfg       cfg_valid/cfg_ready    cfg_index, cfg_data (register write)
//  request   req_valid/req_ready    req_type, entry_index, sector_value, byte_offset
//  result    res_valid/res_ready    sector, out_of_range (one per lookup)
//
// One request is taken per cycle when nothing stalls; the rate is set by the
// single write or read port of each sector table in the back part.
// A lookup result passes through the queue entry, the table read register and
// then the result register before it is offered. Writes produce no result.
// Reset clears the configuration registers and all handshake state. The
// sector tables are not cleared; there is no clearing pass.
// A stalled result fills the read stage and then the two-entry queue before
// req_ready drops. Configuration writes are taken in every cycle.
module file_offset_to_sector_map #(
	parameter int SECTOR_BYTES        = 256,
	parameter int POINTERS_PER_SECTOR = 64,
	parameter int DIRECT_SLOTS        = 62
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fom_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fom_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [fom_pkg::TYPE_W-1:0]      req_type,
	input  logic [fom_pkg::IDX_W-1:0]       entry_index,
	input  logic [fom_pkg::SEC_W-1:0]       sector_value,
	input  logic [fom_pkg::OFF_W-1:0]       byte_offset,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [fom_pkg::SEC_W-1:0]       sector,
	output logic                            out_of_range
);
	import fom_pkg::*;

	// Classified request from the front part, waiting for the queue.
	logic fr_valid;
	logic fr_ready;
	op_t  fr_op;

	// Head of the queue, consumed by the back part.
	logic qb_valid;
	logic qb_ready;
	op_t  qb_op;

	// The front part holds the layout registers and turns each request into a
	// table write, a table read at a computed entry, or a range miss.
	fom_front #(
		.SECTOR_BYTES        (SECTOR_BYTES),
		.POINTERS_PER_SECTOR (POINTERS_PER_SECTOR),
		.DIRECT_SLOTS        (DIRECT_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.sector_value (sector_value),
		.byte_offset  (byte_offset),
		.op_valid     (fr_valid),
		.op_ready     (fr_ready),
		.op           (fr_op)
	);

	// The queue lets the front keep taking requests while a result waits.
	fom_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_op     (fr_op),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_op    (qb_op)
	);

	// The back part owns the tables, performs the writes and reads, and holds
	// the result register.
	fom_back #(
		.POINTERS_PER_SECTOR (POINTERS_PER_SECTOR),
		.DIRECT_SLOTS        (DIRECT_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (qb_valid),
		.op_ready     (qb_ready),
		.op           (qb_op),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.sector       (sector),
		.out_of_range (out_of_range)
	);

endmodule
